### rtl/sorted_array_priority_queue_defines.svh
// assertion macros for the sorted array priority queue
// taken in by the top level; needs nothing else
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SAPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sapq check failed in the same cycle");

// antecedent implies consequent in the next cycle
`define SAPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sapq check failed one cycle later");

`endif

### rtl/sapq_pkg.sv
// shared types and codes for the sorted array priority queue
// used by sapq_cell and sorted_array_priority_queue; depends on nothing
package sapq_pkg;

    localparam int DATA_W = 32;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } sapq_status_t;

    // input item
    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] value;
    } sapq_in_t;

    // result item
    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        sapq_status_t             status;
        logic                     is_empty;
    } sapq_out_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } sapq_ctl_t;

endpackage

### rtl/sapq_cell.sv
// one cell of the queue: holds one entry, compares it with the new value
// and shifts with its neighbors; depends on sapq_pkg
module sapq_cell import sapq_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                     aclk,
    input  sapq_ctl_t                ctl,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0] left_entry,
    input  logic                     left_gt,
    input  logic signed [DATA_W-1:0] right_entry,
    output logic signed [DATA_W-1:0] entry,
    output logic                     gt
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     occupied;

    // cells hold entries in decreasing order from index zero
    assign occupied = (count > CNT_W'(INDEX));
    assign gt       = occupied && (entry_reg > ctl.value);
    assign entry    = entry_reg;

    // insert: larger entries stay, the first slot that is not larger takes
    // the new value, the rest move one place away from the head
    // delete: every entry moves one place toward the head
    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (!gt) begin
                entry_next = left_gt ? ctl.value : left_entry;
            end
        end else if (ctl.del) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/sorted_array_priority_queue.sv
// Sorted array priority queue, top level.
// Input channel s_valid/s_ready/s_data carries an item: func selects insert
// or delete-max, value is the signed word to insert. Output channel
// m_valid/m_ready/m_data carries exactly one result item per input item:
// max_value (the removed maximum on a good delete, else zero), status
// (ok, insert rejected when full, delete rejected when empty) and is_empty.
// Entries sit in a row of CAPACITY cells kept in decreasing order, so the
// maximum is always in cell zero. Every cell compares its own entry with
// the new value at once and shifts with its neighbors in the same cycle.
// The result is registered: it is on m_data in the cycle after acceptance.
// Throughput is one item per cycle while the receiver takes each result;
// the limit is the single output register, refilled in the cycle it is taken.
// When the receiver stalls, the result holds on m_data and s_ready drops
// until it is taken.
// Reset (aresetn low, synchronous) empties the queue and drops m_valid;
// s_ready stays low while reset is held. There is no clearing pass, the
// block takes items right after reset.
`include "sorted_array_priority_queue_defines.svh"

module sorted_array_priority_queue import sapq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sapq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sapq_out_t m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    sapq_out_t                m_data_reg;
    sapq_out_t                m_data_next;

    logic                     accept;
    logic                     is_full;
    logic                     is_emp;
    logic                     ins_ok;
    logic                     del_ok;
    sapq_ctl_t                ctl;

    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic                     gt_w    [CAPACITY];

    // handshake
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // request decode
    assign is_full = (count_reg == CNT_W'(CAPACITY));
    assign is_emp  = (count_reg == '0);
    assign ins_ok  = accept && (s_data.func == OP_INSERT) && !is_full;
    assign del_ok  = accept && (s_data.func == OP_DELETE) && !is_emp;

    assign ctl.ins   = ins_ok;
    assign ctl.del   = del_ok;
    assign ctl.value = s_data.value;

    // row of cells
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic signed [DATA_W-1:0] left_entry;
        logic                     left_gt;
        logic signed [DATA_W-1:0] right_entry;

        if (j == 0) begin : g_head
            assign left_entry = '0;
            assign left_gt    = 1'b1;
        end else begin : g_mid
            assign left_entry = entry_w[j-1];
            assign left_gt    = gt_w[j-1];
        end

        if (j == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = entry_w[j+1];
        end

        sapq_cell #(
            .INDEX (j),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (entry_w[j]),
            .gt          (gt_w[j])
        );
    end

    // count and result
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            if (ins_ok) begin
                count_next = count_reg + CNT_W'(1);
            end else if (del_ok) begin
                count_next = count_reg - CNT_W'(1);
            end
            m_valid_next         = 1'b1;
            m_data_next.max_value = del_ok ? entry_w[0] : '0;
            if (s_data.func == OP_INSERT) begin
                m_data_next.status = is_full ? ST_FULL : ST_OK;
            end else begin
                m_data_next.status = is_emp ? ST_EMPTY : ST_OK;
            end
            m_data_next.is_empty = (count_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // checks
    `SAPQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SAPQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, ins_ok, count_reg == $past(count_reg) + CNT_W'(1))
    `SAPQ_ASSERT_SAME(a_empty_flag, aclk, aresetn, m_valid_reg, m_data_reg.is_empty == (count_reg == '0))
    `SAPQ_ASSERT_SAME(a_head_order, aclk, aresetn, count_reg >= CNT_W'(2), entry_w[0] >= entry_w[1])

endmodule

### verif/sorted_array_priority_queue_tb.sv
// self-checking testbench for the sorted array priority queue
// drives random and directed insert and delete-max items; needs sapq_pkg and the rtl
module sorted_array_priority_queue_tb;
    import sapq_pkg::*;

    localparam int QUEUE_DEPTH      = 16;
    localparam int RECV_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_PRINTED      = 40;

    // shadow of the queue contents plus the results still owed by the block
    class sorted_queue_shadow;
        logic signed [DATA_W-1:0] entries [QUEUE_DEPTH];
        int                       entry_count;
        sapq_out_t                owed_results [$];
        int                       error_count;

        function new();
            entry_count = 0;
            error_count = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        task report(string msg);
            error_count++;
            if (error_count <= MAX_PRINTED) $display("mismatch: %s", msg);
        endtask

        // apply one accepted item to the shadow and queue what it should return
        function void note_request(sapq_in_t req);
            sapq_out_t                res;
            logic signed [DATA_W-1:0] val;
            int                       pos;
            res.max_value = '0;
            res.status    = ST_OK;
            val           = $signed(req.value);
            if (req.func == OP_INSERT) begin
                if (entry_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // larger entries move up, equal ones stay below the new value
                    pos = entry_count;
                    while (pos > 0 && $signed(entries[pos-1]) > val) begin
                        entries[pos] = entries[pos-1];
                        pos--;
                    end
                    entries[pos] = val;
                    entry_count++;
                end
            end else begin
                if (entry_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    entry_count--;
                    res.max_value = entries[entry_count];
                end
            end
            res.is_empty = (entry_count == 0);
            owed_results.push_back(res);
        endfunction

        // compare one taken result with the oldest owed one
        task check_result(sapq_out_t got);
            sapq_out_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result max_value %h status %0d is_empty %b",
                                 got.max_value, got.status, got.is_empty));
                return;
            end
            want = owed_results.pop_front();
            if (got.max_value !== want.max_value)
                report($sformatf("max_value got %h want %h", got.max_value, want.max_value));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.is_empty !== want.is_empty)
                report($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
        endtask
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sapq_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sapq_out_t m_data;

    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 71;
    bit          hold_request  = 1'b0;

    sorted_queue_shadow shadow = new();

    sorted_array_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic sapq_in_t make_request(logic func, logic [DATA_W-1:0] value);
        sapq_in_t req;
        req.func  = func;
        req.value = value;
        return req;
    endfunction

    // random value: extremes, a narrow band that gives many equal keys, or any word
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3, 4: return int'($urandom_range(15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // offer one item, with random gaps ahead of it, and hold it until taken
    task automatic offer_request(sapq_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(req);
    endtask

    // wait until the block has returned every owed result
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (shadow.owed_results.size() != 0) @(posedge aclk);
    endtask

    // random items; the insert share swings so the queue runs full and empty often
    task automatic run_random(int n_items, int hold_at);
        int unsigned insert_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 48 == 0) begin
                case ($urandom_range(4))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    2:       insert_pct = 50;
                    3:       insert_pct = 65;
                    default: insert_pct = 35;
                endcase
            end
            if (i == hold_at) hold_request = 1'b1;
            offer_request(make_request(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE,
                                       pick_value()));
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (RECV_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge aclk);
            if (m_valid && m_ready) shadow.check_result(m_data);
        end
    end

    // watchdog on cycles with no item moving on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("sorted_array_priority_queue regression: fail");
        $finish;
    end

    // stimulus and end of run
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: delete when empty, fill with extremes and equal keys, insert when full
        offer_request(make_request(OP_DELETE, 32'h1234_5678));
        offer_request(make_request(OP_INSERT, 32'h0000_0000));
        offer_request(make_request(OP_INSERT, 32'h7fff_ffff));
        offer_request(make_request(OP_INSERT, 32'h8000_0000));
        offer_request(make_request(OP_INSERT, 32'hffff_ffff));
        offer_request(make_request(OP_INSERT, 32'h0000_0001));
        offer_request(make_request(OP_INSERT, 32'h0000_0005));
        offer_request(make_request(OP_INSERT, 32'h0000_0005));
        offer_request(make_request(OP_INSERT, 32'h0000_0005));
        offer_request(make_request(OP_INSERT, 32'hffff_fffb));
        offer_request(make_request(OP_INSERT, 32'h7fff_ffff));
        offer_request(make_request(OP_INSERT, 32'h8000_0000));
        offer_request(make_request(OP_INSERT, 32'h4000_0000));
        offer_request(make_request(OP_INSERT, 32'hc000_0000));
        offer_request(make_request(OP_INSERT, 32'h0000_0003));
        offer_request(make_request(OP_INSERT, 32'hffff_fffe));
        offer_request(make_request(OP_INSERT, 32'h0000_0005));
        offer_request(make_request(OP_INSERT, 32'h0000_0064));
        repeat (4) offer_request(make_request(OP_DELETE, 32'hffff_ffff));

        run_random(626, -1);
        wait_for_drain();

        send_idle_pct = 71;
        recv_idle_pct = 25;
        run_random(626, -1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(626, 200);

        // let the last results out, then look for stray ones
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.owed_results.size() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.owed_results.size()));

        if (shadow.error_count == 0) begin
            $display("sorted_array_priority_queue regression: pass");
        end else begin
            $display("sorted_array_priority_queue regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sapq_pkg.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_queue.sv
verif/sorted_array_priority_queue_tb.sv
